>>> src/eatv_pkg.sv
// shared constants, types and codes for the encoder angle, turns and velocity block
package eatv_pkg;

  // angle format: one turn is 2**CPR_W counts
  localparam int CPR_W         = 14;
  localparam int CPR           = 1 << CPR_W;
  localparam int HALF_TURN     = CPR / 2;

  // offset table: one entry per segment of 2**SEG_SHIFT counts
  localparam int SEG_SHIFT     = 7;
  localparam int TAB_AW        = CPR_W - SEG_SHIFT;
  localparam int TABLE_ENTRIES = 1 << TAB_AW;
  localparam int OFF_W         = 15;

  // velocity window
  localparam int WIN_AW        = 3;
  localparam int VEL_WINDOW    = 1 << WIN_AW;
  localparam int DELTA_W       = 15;
  localparam int DSUM_W        = 18;

  // register and result widths
  localparam int TURNS_W       = 32;
  localparam int PP_W          = 7;
  localparam int RATE_W        = 17;
  localparam int VNUM_W        = DSUM_W + RATE_W + 1;
  localparam int MECH_W        = 34;
  localparam int ELEC_W        = 40;
  // q16.16 scale over window * counts per turn, both powers of two
  localparam int VEL_SHIFT     = $clog2(VEL_WINDOW * CPR) - 16;

  // port widths
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 136;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 17;

  // reset values of the registers
  localparam int PP_RESET      = 7;
  localparam int RATE_RESET    = 10000;

  typedef logic [CPR_W-1:0]         count_t;
  typedef logic [TAB_AW-1:0]        tab_addr_t;
  typedef logic signed [OFF_W-1:0]  offset_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [DSUM_W-1:0] dsum_t;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_TABLE  = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CALIB   = 3'd0,
    CFG_DIR     = 3'd1,
    CFG_POLES   = 3'd2,
    CFG_EOFFSET = 3'd3,
    CFG_RATE    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORR,
    ST_TRACK,
    ST_MUL1,
    ST_MUL2,
    ST_OUT
  } state_t;

  // control from the sequencer to the delta window
  typedef struct packed {
    logic rd;   // fetch the oldest delta
    logic upd;  // replace the oldest delta and update the sum
  } win_ctrl_t;

endpackage

>>> src/eatv_offset_mem.sv
// offset table memory, one write port and two registered read ports
module eatv_offset_mem (
  input  logic               clk,
  input  logic               wr_en,
  input  eatv_pkg::tab_addr_t wr_addr,
  input  eatv_pkg::offset_t  wr_data,
  input  logic               rd_en,
  input  eatv_pkg::tab_addr_t rd_addr0,
  input  eatv_pkg::tab_addr_t rd_addr1,
  output eatv_pkg::offset_t  rd_data0,
  output eatv_pkg::offset_t  rd_data1
);
  import eatv_pkg::*;

  offset_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

>>> src/eatv_delta_win.sv
// ring of recent position deltas with running window sum
module eatv_delta_win (
  input  logic                clk,
  input  logic                rst,
  input  eatv_pkg::win_ctrl_t ctrl,
  input  eatv_pkg::delta_t    delta_in,
  output eatv_pkg::dsum_t     delta_sum
);
  import eatv_pkg::*;

  delta_t                hist_mem [VEL_WINDOW];
  logic [VEL_WINDOW-1:0] hist_valid;
  logic [WIN_AW-1:0]     ptr;
  delta_t                old_q;
  logic                  old_valid;
  delta_t                old_delta;

  // never-written slots count as zero
  assign old_delta = old_valid ? old_q : '0;

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      hist_mem[ptr] <= delta_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      old_q     <= hist_mem[ptr];
      old_valid <= hist_valid[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
      ptr        <= '0;
      delta_sum  <= '0;
    end else if (ctrl.upd) begin
      hist_valid[ptr] <= 1'b1;
      ptr             <= ptr + 1'b1;
      delta_sum       <= delta_sum - dsum_t'(old_delta) + dsum_t'(delta_in);
    end
  end

endmodule

>>> src/encoder_angle_turns_velocity.sv
// top level: encoder angle linearization, turn tracking and velocity estimate
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-----------------------------------------------
//  s_*      | in  | s_tvalid / s_tready | tuser: action; tdata: raw, index, table value
//  m_*      | out | m_tvalid / m_tready | tdata: count, turns, angle, mech vel, elec vel
//  cfg_*    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// a sample item walks the correct, track, multiply and output states from accept
// to the output register load, a table write only the multiply and output states;
// the next item is accepted on the cycle after the result loads; the cost is the offset
// table read, the delta ring update and two chained multiplies (scale, then pole pairs)
// synchronous reset clears registers, turns, last count and the delta window;
// the offset table holds no reset value
// a stalled output holds its result while the next item is already accepted
module encoder_angle_turns_velocity (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [13:0] raw_angle, [20:14] table_index, [35:21] table_value, [39:36] zero
  input  logic [eatv_pkg::IN_TDATA_W-1:0]   s_tdata,
  // [0] action
  input  logic                              s_tuser,
  // result items
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [13:0] corrected_count, [45:14] turn_count, [59:46] electrical_angle,
  // [93:60] mechanical_velocity, [133:94] electrical_velocity, [135:134] zero
  output logic [eatv_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [eatv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [eatv_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import eatv_pkg::*;

  localparam logic signed [CPR_W+1:0] HALF_S = (CPR_W+2)'(HALF_TURN);
  localparam logic signed [CPR_W+1:0] CPR_S  = (CPR_W+2)'(CPR);

  // configuration
  logic              calib_en;
  logic              dir_rev;
  logic [PP_W-1:0]   pole_count;
  count_t            elec_offset;
  logic [RATE_W-1:0] sample_rate;

  // sequencer
  state_t    state, state_next;
  logic      accept;
  logic      mem_rd;
  logic      mem_wr;
  win_ctrl_t win_ctrl;
  logic      out_load;

  // input fields
  action_t   in_action;
  count_t    in_raw;
  tab_addr_t in_idx;
  offset_t   in_val;

  // sample mirror and table addresses
  count_t    raw_m;
  tab_addr_t seg;
  tab_addr_t seg_nxt;

  // tracked state
  count_t               last_count;
  logic [TURNS_W-1:0]   turns;

  // datapath registers
  count_t                     raw_q;
  count_t                     cnt_q;
  count_t                     angle_q;
  logic signed [VNUM_W-1:0]   vnum_q;
  logic signed [MECH_W-1:0]   mech_q;
  logic signed [ELEC_W-1:0]   elec_q;

  // interpolation
  offset_t                          e0, e1;
  logic [SEG_SHIFT-1:0]             frac;
  logic signed [OFF_W:0]            e_diff;
  logic signed [OFF_W+SEG_SHIFT:0]  interp;
  logic signed [OFF_W+1:0]          off;
  count_t                           cnt_corr;

  // turn tracking
  logic signed [CPR_W+1:0] d_w;
  logic signed [CPR_W+1:0] delta_w;
  logic                    turn_up;
  logic                    turn_dn;
  delta_t                  delta;
  dsum_t                   delta_sum;

  // output arithmetic
  count_t                     e_rel;
  logic [PP_W+CPR_W-1:0]      ang_full;
  logic signed [VNUM_W-1:0]   vnum;
  logic signed [MECH_W-1:0]   mech;
  logic signed [MECH_W+PP_W:0] elec_full;

  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign in_action = action_t'(s_tuser);
  assign in_raw    = s_tdata[CPR_W-1:0];
  assign in_idx    = s_tdata[CPR_W +: TAB_AW];
  assign in_val    = s_tdata[CPR_W+TAB_AW +: OFF_W];

  // mirrored reading: (cpr - raw) mod cpr
  assign raw_m   = dir_rev ? count_t'(count_t'(0) - in_raw) : in_raw;
  assign seg     = raw_m[CPR_W-1 -: TAB_AW];
  assign seg_nxt = seg + 1'b1;

  eatv_offset_mem u_offset_mem (
    .clk      (clk),
    .wr_en    (mem_wr),
    .wr_addr  (in_idx),
    .wr_data  (in_val),
    .rd_en    (mem_rd),
    .rd_addr0 (seg),
    .rd_addr1 (seg_nxt),
    .rd_data0 (e0),
    .rd_data1 (e1)
  );

  eatv_delta_win u_delta_win (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (win_ctrl),
    .delta_in  (delta),
    .delta_sum (delta_sum)
  );

  // offset = e0 + floor((e1 - e0) * frac / segment size), count wraps mod cpr
  assign frac     = raw_q[SEG_SHIFT-1:0];
  assign e_diff   = (OFF_W+1)'(e1) - (OFF_W+1)'(e0);
  assign interp   = e_diff * $signed({1'b0, frac});
  assign off      = (OFF_W+2)'(e0) + (OFF_W+2)'(interp >>> SEG_SHIFT);
  assign cnt_corr = calib_en ? count_t'(raw_q - off) : raw_q;

  // half-turn jump rule
  assign d_w     = $signed({2'b00, cnt_q}) - $signed({2'b00, last_count});
  assign turn_dn = d_w > HALF_S;
  assign turn_up = d_w < -HALF_S;
  assign delta_w = turn_dn ? d_w - CPR_S : (turn_up ? d_w + CPR_S : d_w);
  assign delta   = delta_t'(delta_w);

  // electrical angle keeps the low bits of the product, which is the floor mod
  assign e_rel     = last_count - elec_offset;
  assign ang_full  = pole_count * e_rel;
  assign vnum      = delta_sum * $signed({1'b0, sample_rate});
  assign mech      = MECH_W'(vnum_q >>> VEL_SHIFT);
  assign elec_full = mech * $signed({1'b0, pole_count});

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_rd     = 1'b0;
    mem_wr     = 1'b0;
    win_ctrl   = '0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (in_action == ACT_TABLE) begin
            mem_wr     = 1'b1;
            state_next = ST_MUL1;
          end else begin
            mem_rd      = 1'b1;
            win_ctrl.rd = 1'b1;
            state_next  = ST_CORR;
          end
        end
      end
      ST_CORR: begin
        state_next = ST_TRACK;
      end
      ST_TRACK: begin
        win_ctrl.upd = 1'b1;
        state_next   = ST_MUL1;
      end
      ST_MUL1: begin
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      raw_q <= raw_m;
    end
    if (state == ST_CORR) begin
      cnt_q <= cnt_corr;
    end
    if (state == ST_MUL1) begin
      angle_q <= ang_full[CPR_W-1:0];
      vnum_q  <= vnum;
    end
    if (state == ST_MUL2) begin
      mech_q <= mech;
      elec_q <= ELEC_W'(elec_full);
    end
    if (out_load) begin
      m_tdata <= {{(OUT_TDATA_W-ELEC_W-MECH_W-2*CPR_W-TURNS_W){1'b0}},
                  elec_q, mech_q, angle_q, turns, last_count};
    end
  end

  // configuration, tracked position and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_en    <= 1'b0;
      dir_rev     <= 1'b0;
      pole_count  <= PP_W'(PP_RESET);
      elec_offset <= '0;
      sample_rate <= RATE_W'(RATE_RESET);
      last_count  <= '0;
      turns       <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_CALIB:   calib_en    <= cfg_data[0];
          CFG_DIR:     dir_rev     <= cfg_data[0];
          CFG_POLES:   pole_count  <= cfg_data[PP_W-1:0];
          CFG_EOFFSET: elec_offset <= cfg_data[CPR_W-1:0];
          CFG_RATE:    sample_rate <= cfg_data[RATE_W-1:0];
          default: begin
          end
        endcase
      end
      if (state == ST_TRACK) begin
        last_count <= cnt_q;
        if (turn_dn) begin
          turns <= turns - 1'b1;
        end else if (turn_up) begin
          turns <= turns + 1'b1;
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // a sample reaches the output stage after a fixed walk through the sequencer
  a_sample_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == ACT_SAMPLE) |-> ##5 (state == ST_OUT))
    else $error("sample did not reach output stage on time");

  // a table write skips correction and tracking and only reports held state
  a_table_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == ACT_TABLE) |-> ##3 (state == ST_OUT))
    else $error("table write did not reach output stage on time");

  // turns move by at most one per step
  a_turn_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (turns == $past(turns) || turns == $past(turns) + 32'd1 ||
                     turns == $past(turns) - 32'd1))
    else $error("turn count jumped by more than one");

  // tracked position only moves in the tracking step
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_TRACK) |=> $stable(last_count))
    else $error("last count changed outside tracking step");

endmodule

>>> tb/encoder_readout_checker.sv
// result checker: tracks the encoder state from the input side and compares every result item
`timescale 1ns / 1ps

module encoder_readout_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [eatv_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [eatv_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [eatv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eatv_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               readouts_owed,
  output int                               miscompares
);
  import eatv_pkg::*;

  // field positions in the item words
  localparam int IDX_LSB     = CPR_W;
  localparam int VAL_LSB     = IDX_LSB + TAB_AW;
  localparam int TURNS_LSB   = CPR_W;
  localparam int ANGLE_LSB   = TURNS_LSB + TURNS_W;
  localparam int MECH_LSB    = ANGLE_LSB + CPR_W;
  localparam int ELEC_LSB    = MECH_LSB + MECH_W;
  // q16.16 turns/s: times 65536, over window * counts per turn
  localparam int SCALE_SHIFT = $clog2(VEL_WINDOW * CPR);

  typedef struct packed {
    count_t              count;
    logic [TURNS_W-1:0]  turns;
    count_t              angle;
    logic [MECH_W-1:0]   mech_vel;
    logic [ELEC_W-1:0]   elec_vel;
  } readout_t;

  // register copies
  logic   calib_on;
  logic   dir_rev;
  int     poles;
  int     elec_zero;
  int     rate_hz;

  // encoder state
  offset_t            offsets [TABLE_ENTRIES];
  int                 prev_count;
  logic [TURNS_W-1:0] turn_acc;
  int                 deltas [VEL_WINDOW];
  int                 delta_total;

  readout_t readouts_due [$];
  int       errs = 0;

  function automatic readout_t readout_now();
    readout_t r;
    longint   diff, angle, mech, elec;
    diff  = longint'(prev_count) - longint'(elec_zero);
    angle = (longint'(poles) * diff) & (CPR - 1);
    mech  = (longint'(delta_total) * longint'(rate_hz) * 65536) >>> SCALE_SHIFT;
    elec  = mech * longint'(poles);
    r.count    = prev_count[CPR_W-1:0];
    r.turns    = turn_acc;
    r.angle    = angle[CPR_W-1:0];
    r.mech_vel = mech[MECH_W-1:0];
    r.elec_vel = elec[ELEC_W-1:0];
    return r;
  endfunction

  // one angle sample: mirror, linearize, count turns, slide the delta window
  function automatic void step_encoder(input int raw_in);
    int raw, cnt, seg, e0, e1, frac, off, d, delta;
    raw = raw_in;
    if (dir_rev)
      raw = (CPR - raw) % CPR;
    cnt = raw;
    if (calib_on) begin
      seg  = raw >> SEG_SHIFT;
      e0   = offsets[seg];
      e1   = offsets[(seg + 1) % TABLE_ENTRIES];
      frac = raw & ((1 << SEG_SHIFT) - 1);
      off  = e0 + (((e1 - e0) * frac) >>> SEG_SHIFT);
      cnt  = (raw - off) & (CPR - 1);
    end
    d = cnt - prev_count;
    delta = d;
    if (d > HALF_TURN) begin
      turn_acc = turn_acc - 1'b1;
      delta = d - CPR;
    end else if (d < -HALF_TURN) begin
      turn_acc = turn_acc + 1'b1;
      delta = d + CPR;
    end
    prev_count = cnt;
    delta_total = delta_total - deltas[VEL_WINDOW-1];
    for (int i = VEL_WINDOW - 1; i > 0; i--)
      deltas[i] = deltas[i-1];
    deltas[0] = delta;
    delta_total = delta_total + delta;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    readout_t want;
    if (rst) begin
      calib_on    = 1'b0;
      dir_rev     = 1'b0;
      poles       = PP_RESET;
      elec_zero   = 0;
      rate_hz     = RATE_RESET;
      prev_count  = 0;
      turn_acc    = '0;
      delta_total = 0;
      for (int i = 0; i < VEL_WINDOW; i++)
        deltas[i] = 0;
      readouts_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (readouts_due.size() == 0) begin
          $error("result item with none expected: count 'h%0h", m_tdata[0 +: CPR_W]);
          errs++;
        end else begin
          want = readouts_due.pop_front();
          check_field("corrected_count", want.count, m_tdata[0 +: CPR_W]);
          check_field("turn_count", want.turns, m_tdata[TURNS_LSB +: TURNS_W]);
          check_field("electrical_angle", want.angle, m_tdata[ANGLE_LSB +: CPR_W]);
          check_field("mechanical_velocity", want.mech_vel, m_tdata[MECH_LSB +: MECH_W]);
          check_field("electrical_velocity", want.elec_vel, m_tdata[ELEC_LSB +: ELEC_W]);
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CALIB:   calib_on  = cfg_data[0];
          CFG_DIR:     dir_rev   = cfg_data[0];
          CFG_POLES:   poles     = cfg_data[PP_W-1:0];
          CFG_EOFFSET: elec_zero = cfg_data[CPR_W-1:0];
          CFG_RATE:    rate_hz   = cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser == ACT_TABLE)
          offsets[s_tdata[IDX_LSB +: TAB_AW]] = s_tdata[VAL_LSB +: OFF_W];
        else
          step_encoder(s_tdata[0 +: CPR_W]);
        readouts_due.push_back(readout_now());
      end
    end
    readouts_owed <= readouts_due.size();
    miscompares   <= errs;
  end

endmodule

>>> tb/tb_top.sv
// testbench top: drives sample and table items and register writes, gives the verdict
`timescale 1ns / 1ps

module tb_top;
  import eatv_pkg::*;

  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 220;
  localparam int NUM_REGS        = 5;
  // quiet time after the last result is out, before touching registers
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 16;
  // cycles with no item, result or write accepted before the run is declared hung
  localparam int IDLE_LIMIT      = 1000;
  localparam int OFF_MIN         = -(1 << (OFF_W - 1));
  localparam int OFF_MAX         = (1 << (OFF_W - 1)) - 1;
  localparam int RATE_MAX        = 100000;
  localparam int POLES_MAX       = 64;

  typedef enum int {
    RDY_FREE,     // always ready
    RDY_COIN,     // ready on a coin toss
    RDY_PATTERN   // fixed blocks of stall and ready
  } ready_mode_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int readouts_owed;
  int miscompares;
  int idle_cycles = 0;
  int burst_left  = 0;
  // simulated shaft for well-formed motion sequences
  int shaft_pos   = 0;
  int shaft_speed = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  encoder_angle_turns_velocity u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  encoder_readout_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .readouts_owed (readouts_owed),
    .miscompares   (miscompares)
  );

  // result side back-pressure: mode, stall and open lengths are picked anew when a mode runs out
  ready_mode_t ready_mode  = RDY_FREE;
  int          mode_left   = 0;
  int          pat_count   = 0;
  int          stall_len   = 1;
  int          open_len    = 1;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(32, 256);
      stall_len  = $urandom_range(1, 12);
      open_len   = $urandom_range(1, 8);
      pat_count  = 0;
    end else begin
      mode_left = mode_left - 1;
    end
    case (ready_mode)
      RDY_FREE: m_tready <= 1'b1;
      RDY_COIN: m_tready <= 1'($urandom_range(0, 1));
      default: begin
        // stall first, then open, over and over
        m_tready <= (pat_count % (stall_len + open_len)) >= stall_len;
        pat_count = pat_count + 1;
      end
    endcase
  end

  // hang watchdog: any accepted item, taken result or register write restarts the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one item; the sender runs in bursts with random gaps between
  task automatic send_item(input action_t act, input int raw, input int idx, input int val);
    logic [IN_TDATA_W-1:0] word;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    word = '0;
    word[0 +: CPR_W]             = raw[CPR_W-1:0];
    word[CPR_W +: TAB_AW]        = idx[TAB_AW-1:0];
    word[CPR_W + TAB_AW +: OFF_W] = val[OFF_W-1:0];
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    burst_left = burst_left - 1;
  endtask

  // unused fields carry random bits so the block is seen to ignore them
  task automatic send_sample(input int raw);
    send_item(ACT_SAMPLE, raw, $urandom_range(0, TABLE_ENTRIES - 1),
              $urandom_range(0, (1 << OFF_W) - 1));
  endtask

  task automatic send_table(input int idx, input int val);
    send_item(ACT_TABLE, $urandom_range(0, CPR - 1), idx, val);
  endtask

  // mostly smooth shaft motion at varying speed, some noise and table rewrites
  task automatic send_random_item();
    int pick, span;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_table($urandom_range(0, TABLE_ENTRIES - 1), $urandom_range(0, (1 << OFF_W) - 1));
    end else if (pick < 12) begin
      send_sample($urandom_range(0, CPR - 1));
    end else begin
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0:       span = 20;
          1:       span = 400;
          2:       span = 3000;
          default: span = HALF_TURN - 2;  // near the half-turn jump limit
        endcase
        shaft_speed = int'($urandom_range(0, 2 * span)) - span;
      end
      shaft_pos = (shaft_pos + shaft_speed + int'($urandom_range(0, 6)) - 3) & (CPR - 1);
      send_sample(shaft_pos);
    end
  endtask

  // stop sending and wait until every result is out and the block is quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (readouts_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all registers back to back, valid stays high between writes
  task automatic load_settings(input int calib, input int dir, input int poles,
                               input int zero, input int rate);
    cfg_reg_t regs [NUM_REGS];
    int       vals [NUM_REGS];
    regs = '{CFG_CALIB, CFG_DIR, CFG_POLES, CFG_EOFFSET, CFG_RATE};
    vals = '{calib, dir, poles, zero, rate};
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i][CFG_DATA_W-1:0];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase;
    int rand_poles;
    int rand_zero;
    int rand_rate;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset register values; first sample measures its delta from count zero
    send_sample(CPR - 1);        // jump down past half a turn
    send_sample(0);              // jump back up
    send_sample(HALF_TURN);      // exactly half a turn: no turn change
    send_sample(0);              // exactly minus half a turn: no turn change
    send_sample(HALF_TURN + 1);  // just past half a turn
    // table writes report the held state and change nothing else
    send_table(0, OFF_MIN);
    send_table(TABLE_ENTRIES - 1, OFF_MAX);
    // fill the rest so calibration never reads an unwritten entry
    for (int i = 1; i < TABLE_ENTRIES - 1; i++)
      send_table(i, $urandom_range(0, (1 << OFF_W) - 1));
    settle();

    // mirror and calibration together, the bench's largest pole, zero and rate values
    load_settings(1, 1, POLES_MAX, CPR - 1, RATE_MAX);
    send_sample(0);               // mirrors onto itself
    send_sample(1);               // mirrors into the last segment, interpolates toward entry 0
    send_sample(CPR - 1);
    send_sample((1 << SEG_SHIFT) - 1);
    send_sample(1 << SEG_SHIFT);
    send_sample(HALF_TURN);
    settle();

    // zero pole pairs and zero sample rate: angle and velocities go to zero
    load_settings(0, 0, 0, 0, 0);
    send_sample(5000);
    send_sample(100);
    send_sample(16000);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      rand_poles = $urandom_range(1, POLES_MAX);
      rand_zero  = $urandom_range(0, CPR - 1);
      rand_rate  = $urandom_range(1, RATE_MAX);
      case (phase)
        0:       load_settings(0, 0, 1, 0, 1);
        1:       load_settings(1, 0, POLES_MAX, CPR - 1, RATE_MAX);
        2:       load_settings(1, 1, rand_poles, rand_zero, rand_rate);
        3:       load_settings(0, 1, rand_poles, rand_zero, rand_rate);
        4:       load_settings(1, 0, rand_poles, rand_zero, rand_rate);
        default: load_settings($urandom_range(0, 1), $urandom_range(0, 1), rand_poles,
                               rand_zero, rand_rate);
      endcase
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (miscompares == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
